### rtl/hpfd_pkg.sv
`timescale 1ns / 1ps
// Package for the heartbeat phi failure detector.
// Holds status codes, sequencer states and fixed field widths. No dependencies.
package hpfd_pkg;

  localparam int TIME_W    = 48;  // timestamp width
  localparam int IVL_W     = 32;  // interval, register and phi width
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 11;  // sample_count field width
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;  // phi fraction bits

  typedef enum logic [STATUS_W-1:0] {
    ST_GAP_STORED  = 3'd0,
    ST_GAP_IGNORED = 3'd1,
    ST_INIT_STORED = 3'd2,
    ST_PHI_VALID   = 3'd3,
    ST_NO_SAMPLES  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL = 2'd0,
    CFG_MAX     = 2'd1,
    CFG_MIN     = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARR_GAP,   // first-arrival check / gap subtract
    S_ARR_CHK,   // gap range compare
    S_ARR_RD,    // read oldest entry
    S_ARR_SUB,   // remove oldest entry from sum
    S_ARR_WR,    // write ring, add to sum
    S_MEAN_LD,   // load divider for mean
    S_Q_ELAP,    // elapsed subtract
    S_Q_MUL,     // elapsed * count
    S_Q_CHK,     // saturation check, load divider
    S_DIV,       // shared divider iterations
    S_FIN        // hand result to output register
  } state_t;

  localparam logic [IVL_W-1:0] PHI_SAT = '1;

endpackage

### rtl/heartbeat_phi_failure_detector.sv
`timescale 1ns / 1ps
// Heartbeat phi failure detector top level: sequencer, interval ring and
// shared 32-step restoring divider. Depends on hpfd_pkg.
//
// One item is worked on at a time; in_tready is high only while the sequencer
// is idle. A query with samples runs elapsed subtract, multiply, saturation
// check, 32 divider steps and hand-off; a query ends early when there are no
// samples, the elapsed time is negative, the window is all zero or phi
// saturates. A stored arrival runs the gap check (skipped on the first
// arrival), an optional eviction read from the ring, the ring write and 32
// divider steps for the new mean; an ignored arrival ends after the gap check.
// The 32-step shared divider sets the rate. Results are held in an output
// register, so a new item may be accepted while the previous result still
// waits. The ring needs no clearing pass: entries are read only for eviction
// once full.
module heartbeat_phi_failure_detector #(
  parameter int WINDOW_DEPTH = 1024  // 1..2047 intervals
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [47:0] time_ms
  input  logic        in_tuser,   // [0] mode: 0 arrival, 1 query
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [31:0] phi_q16, [63:32] mean_ms,
                                  // [74:64] sample_count, [79:75] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = hpfd_pkg::IVL_W + CNT_W;        // sum never overflows
  localparam int NUM_W  = hpfd_pkg::TIME_W + CNT_W;       // elapsed * count
  localparam int REM_W  = SUM_W + 1;                      // divider remainder
  localparam int DIV_N  = hpfd_pkg::IVL_W;                // quotient bits
  localparam int DCNT_W = $clog2(DIV_N);

  localparam int TW = hpfd_pkg::TIME_W;
  localparam int IW = hpfd_pkg::IVL_W;

  // configuration registers
  logic [IW-1:0] initial_ms_r, max_ms_r, min_ms_r;

  // detector state
  logic [TW-1:0]     last_r;
  logic              seen_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  count_r;
  logic [SUM_W-1:0]  sum_r;
  logic [IW-1:0]     mean_r;

  // ring memory
  logic [IW-1:0] ring [WINDOW_DEPTH];
  logic [IW-1:0] ring_rdata_r;
  logic          ring_we, ring_re;

  // per-item working registers
  hpfd_pkg::state_t  state_r, state_nxt;
  logic [TW-1:0]     time_r;
  logic [TW:0]       diff_r;     // gap or elapsed, top bit is borrow
  logic [IW-1:0]     val_r;      // interval to record
  logic [NUM_W-1:0]  num_r;
  hpfd_pkg::status_t status_r;
  logic [IW-1:0]     phi_r;

  // shared divider
  logic [REM_W-1:0]  rem_r;
  logic [DIV_N-1:0]  dlo_r;      // dividend low bits in, quotient bits out
  logic [SUM_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              div_mean_r; // 1: mean, 0: phi
  logic [REM_W-1:0]  trial;
  logic              trial_ge;

  // output register
  logic                        out_valid_r;
  logic [IW-1:0]               out_phi_r, out_mean_r;
  logic [hpfd_pkg::COUNT_W-1:0] out_cnt_r;
  hpfd_pkg::status_t           out_status_r;

  logic full;
  logic in_go, out_go, load_out;
  logic in_range;

  assign full      = (count_r == CNT_W'(WINDOW_DEPTH));
  assign in_tready = (state_r == hpfd_pkg::S_IDLE);
  assign in_go     = in_tvalid && in_tready;
  assign out_go    = out_valid_r && out_tready;
  assign load_out  = (state_r == hpfd_pkg::S_FIN) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  // gap accepted when not negative and inside [min, max]
  assign in_range = !diff_r[TW] &&
                    (diff_r[TW-1:0] <= TW'(max_ms_r)) &&
                    (diff_r[TW-1:0] >= TW'(min_ms_r));

  // divider step: shift in one dividend bit, subtract when it fits
  assign trial    = {rem_r[REM_W-2:0], dlo_r[DIV_N-1]};
  assign trial_ge = (trial >= {1'b0, dvs_r});

  assign ring_re = (state_r == hpfd_pkg::S_ARR_RD);
  assign ring_we = (state_r == hpfd_pkg::S_ARR_WR);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpfd_pkg::S_IDLE: begin
        if (in_go) begin
          state_nxt = in_tuser ? hpfd_pkg::S_Q_ELAP : hpfd_pkg::S_ARR_GAP;
        end
      end
      hpfd_pkg::S_ARR_GAP: begin
        if (!seen_r) begin
          state_nxt = full ? hpfd_pkg::S_ARR_RD : hpfd_pkg::S_ARR_WR;
        end else begin
          state_nxt = hpfd_pkg::S_ARR_CHK;
        end
      end
      hpfd_pkg::S_ARR_CHK: begin
        if (!in_range) begin
          state_nxt = hpfd_pkg::S_FIN;
        end else begin
          state_nxt = full ? hpfd_pkg::S_ARR_RD : hpfd_pkg::S_ARR_WR;
        end
      end
      hpfd_pkg::S_ARR_RD:  state_nxt = hpfd_pkg::S_ARR_SUB;
      hpfd_pkg::S_ARR_SUB: state_nxt = hpfd_pkg::S_ARR_WR;
      hpfd_pkg::S_ARR_WR:  state_nxt = hpfd_pkg::S_MEAN_LD;
      hpfd_pkg::S_MEAN_LD: state_nxt = hpfd_pkg::S_DIV;
      hpfd_pkg::S_Q_ELAP: begin
        state_nxt = (!seen_r || count_r == '0) ? hpfd_pkg::S_FIN : hpfd_pkg::S_Q_MUL;
      end
      hpfd_pkg::S_Q_MUL: begin
        state_nxt = (diff_r[TW] || sum_r == '0) ? hpfd_pkg::S_FIN : hpfd_pkg::S_Q_CHK;
      end
      hpfd_pkg::S_Q_CHK: begin
        state_nxt = (num_r >= {sum_r, {hpfd_pkg::FRAC_W{1'b0}}}) ?
                    hpfd_pkg::S_FIN : hpfd_pkg::S_DIV;
      end
      hpfd_pkg::S_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = hpfd_pkg::S_FIN;
        end
      end
      hpfd_pkg::S_FIN: begin
        if (load_out) begin
          state_nxt = hpfd_pkg::S_IDLE;
        end
      end
      default: state_nxt = hpfd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpfd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_ms_r <= IW'(10000);
      max_ms_r     <= IW'(10000);
      min_ms_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (hpfd_pkg::cfg_idx_t'(cfg_index))
        hpfd_pkg::CFG_INITIAL: initial_ms_r <= cfg_data;
        hpfd_pkg::CFG_MAX:     max_ms_r     <= cfg_data;
        hpfd_pkg::CFG_MIN:     min_ms_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[slot_r] <= val_r;
    end
    if (ring_re) begin
      ring_rdata_r <= ring[slot_r];
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      seen_r  <= 1'b0;
      slot_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
      mean_r  <= '0;
    end else begin
      case (state_r)
        hpfd_pkg::S_ARR_GAP: begin
          last_r <= time_r;
          seen_r <= 1'b1;
        end
        hpfd_pkg::S_ARR_SUB: sum_r <= sum_r - SUM_W'(ring_rdata_r);
        hpfd_pkg::S_ARR_WR: begin
          sum_r <= sum_r + SUM_W'(val_r);
          if (!full) begin
            count_r <= count_r + 1'b1;
          end
          slot_r <= (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        end
        hpfd_pkg::S_DIV: begin
          if (dcnt_r == '0 && div_mean_r) begin
            mean_r <= {dlo_r[DIV_N-2:0], trial_ge};
          end
        end
        default: ;
      endcase
    end
  end

  // per-item datapath and shared divider
  always_ff @(posedge clk) begin
    case (state_r)
      hpfd_pkg::S_IDLE: begin
        if (in_go) begin
          time_r <= in_tdata;
          phi_r  <= '0;
        end
      end
      hpfd_pkg::S_ARR_GAP: begin
        val_r    <= initial_ms_r;
        status_r <= hpfd_pkg::ST_INIT_STORED;
        diff_r   <= {1'b0, time_r} - {1'b0, last_r};
      end
      hpfd_pkg::S_ARR_CHK: begin
        val_r    <= diff_r[IW-1:0];
        status_r <= in_range ? hpfd_pkg::ST_GAP_STORED : hpfd_pkg::ST_GAP_IGNORED;
      end
      hpfd_pkg::S_MEAN_LD: begin
        rem_r      <= REM_W'(sum_r[SUM_W-1:IW]);
        dlo_r      <= sum_r[IW-1:0];
        dvs_r      <= SUM_W'(count_r);
        dcnt_r     <= DCNT_W'(DIV_N - 1);
        div_mean_r <= 1'b1;
      end
      hpfd_pkg::S_Q_ELAP: begin
        diff_r   <= {1'b0, time_r} - {1'b0, last_r};
        status_r <= (!seen_r || count_r == '0) ? hpfd_pkg::ST_NO_SAMPLES
                                               : hpfd_pkg::ST_PHI_VALID;
      end
      hpfd_pkg::S_Q_MUL: begin
        // negative elapsed gives zero; an all-zero window gives 0 or saturation
        if (diff_r[TW]) begin
          phi_r <= '0;
        end else if (sum_r == '0) begin
          phi_r <= (diff_r[TW-1:0] != '0) ? hpfd_pkg::PHI_SAT : '0;
        end
        num_r <= NUM_W'(diff_r[TW-1:0]) * NUM_W'(count_r);
      end
      hpfd_pkg::S_Q_CHK: begin
        // phi = floor((num << 16) / sum); the quotient fits 32 bits unless
        // num >= sum << 16, so the upper dividend bits start as the remainder
        if (num_r >= {sum_r, {hpfd_pkg::FRAC_W{1'b0}}}) begin
          phi_r <= hpfd_pkg::PHI_SAT;
        end
        rem_r      <= REM_W'(num_r[NUM_W-1:hpfd_pkg::FRAC_W]);
        dlo_r      <= {num_r[hpfd_pkg::FRAC_W-1:0], {(IW - hpfd_pkg::FRAC_W){1'b0}}};
        dvs_r      <= sum_r;
        dcnt_r     <= DCNT_W'(DIV_N - 1);
        div_mean_r <= 1'b0;
      end
      hpfd_pkg::S_DIV: begin
        rem_r  <= trial_ge ? trial - {1'b0, dvs_r} : trial;
        dlo_r  <= {dlo_r[DIV_N-2:0], trial_ge};
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == '0 && !div_mean_r) begin
          phi_r <= {dlo_r[DIV_N-2:0], trial_ge};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_go) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_phi_r    <= phi_r;
      out_mean_r   <= mean_r;
      out_cnt_r    <= hpfd_pkg::COUNT_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'b0, out_cnt_r, out_mean_r, out_phi_r};

  // window never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WINDOW_DEPTH))
    else $error("held count beyond window depth");

  // empty window means an empty sum
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> sum_r == '0)
    else $error("nonzero sum with empty window");

  // once any arrival has been seen, the idle sequencer has samples in the window
  a_seen_count: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r && state_r == hpfd_pkg::S_IDLE) |-> count_r != '0)
    else $error("arrival seen but window empty");

  // a valid phi is only reported with samples in the window
  a_phi_samples: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && status_r == hpfd_pkg::ST_PHI_VALID) |=> out_cnt_r != '0 || CNT_W > 11)
    else $error("phi reported without samples");

endmodule

### tb/sv/tb_heartbeat_phi_failure_detector.sv
`timescale 1ns / 1ps
// Self-checking testbench for heartbeat_phi_failure_detector: queue-fed stream driver,
// result monitor, in-bench phi/window predictor and register writes between phases.
// Depends on hpfd_pkg and the detector RTL.
module tb_heartbeat_phi_failure_detector;

  localparam int CLK_PERIOD    = 8;
  localparam int DEPTH         = 1024;
  localparam int SETTLE_CYCLES = 64;    // margin beyond the longest item
  localparam int STALL_LIMIT   = 3000;  // cycles with no transfer on any channel

  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_QUERY   = 1'b1;

  localparam logic [31:0] IVL_MAX  = 32'hFFFF_FFFF;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic                        mode;
    logic [hpfd_pkg::TIME_W-1:0] stamp;
  } beat_item_t;

  typedef struct {
    hpfd_pkg::status_t          status;
    logic [hpfd_pkg::IVL_W-1:0] phi;
    logic [hpfd_pkg::IVL_W-1:0] mean;
    logic [10:0]                count;
  } verdict_t;

  // DUT ports; every input starts at a known value
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        in_tuser   = MODE_ARRIVAL;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = hpfd_pkg::CFG_INITIAL;
  logic [31:0] cfg_data   = '0;

  beat_item_t pending_beats[$];
  verdict_t   expected_verdicts[$];

  int          idle_pct     = 19;
  int          mismatches   = 0;
  int          stall_cycles = 0;
  bit          in_took      = 1'b0;
  logic [47:0] gen_last     = '0;   // last arrival stamp handed to the driver

  // Predictor copy of the detector: registers, window and arrival tracking
  logic [31:0] init_ms = 32'd10000;
  logic [31:0] max_ms  = 32'd10000;
  logic [31:0] min_ms  = 32'd0;
  logic [47:0] last_beat  = '0;
  bit          have_beat  = 1'b0;
  logic [31:0] ring [DEPTH];
  int unsigned slot = 0;
  int unsigned held = 0;
  logic [63:0] win_sum = '0;

  heartbeat_phi_failure_detector #(
    .WINDOW_DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Window update: once full, the oldest slot leaves the sum before it is overwritten
  function automatic void push_interval(logic [31:0] ivl);
    if (held >= DEPTH) begin
      win_sum -= 64'(ring[slot]);
    end else begin
      held++;
    end
    ring[slot] = ivl;
    win_sum += 64'(ivl);
    slot = (slot + 1) % DEPTH;
  endfunction

  // elapsed * count / sum in Q16.16, floor; all-zero window saturates on any nonzero elapsed time
  function automatic logic [31:0] phi_ratio(logic [63:0] elapsed);
    logic [63:0] num, quo, rem, frac;
    if (win_sum == 0) return (elapsed != 0) ? hpfd_pkg::PHI_SAT : '0;
    num = elapsed * 64'(held);
    quo = num / win_sum;
    if (quo >= 64'd65536) return hpfd_pkg::PHI_SAT;
    rem  = num % win_sum;
    frac = (rem << hpfd_pkg::FRAC_W) / win_sum;
    return {quo[15:0], frac[15:0]};
  endfunction

  function automatic verdict_t detector_step(logic mode, logic [47:0] stamp);
    verdict_t    v;
    logic [47:0] diff;
    v.status = hpfd_pkg::ST_NO_SAMPLES;
    v.phi    = '0;
    diff     = stamp - last_beat;
    if (mode == MODE_ARRIVAL) begin
      if (!have_beat) begin
        push_interval(init_ms);
        v.status = hpfd_pkg::ST_INIT_STORED;
      end else if (stamp >= last_beat && 64'(diff) <= 64'(max_ms)
                   && 64'(diff) >= 64'(min_ms)) begin
        push_interval(diff[31:0]);
        v.status = hpfd_pkg::ST_GAP_STORED;
      end else begin
        // backward stamp or gap outside [min, max]
        v.status = hpfd_pkg::ST_GAP_IGNORED;
      end
      last_beat = stamp;  // taken even when the gap is ignored
      have_beat = 1'b1;
    end else if (have_beat && held != 0) begin
      v.status = hpfd_pkg::ST_PHI_VALID;
      if (stamp >= last_beat) v.phi = phi_ratio(64'(diff));
    end
    v.mean  = (held == 0) ? '0 : 32'(win_sum / 64'(held));
    v.count = 11'(held);
    return v;
  endfunction

  // Input side: predict on each accepted transfer, then refill at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_verdicts.insert(expected_verdicts.size(), detector_step(in_tuser, in_tdata));
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin : drive_in
    beat_item_t nxt;
    if (!in_tvalid || in_took) begin
      in_took = 1'b0;
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.mode;
        in_tdata  <= nxt.stamp;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: random back-pressure, compare each transfer with the oldest prediction
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin : check_out
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result transfer: status %0d", out_tuser);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata[31:0] !== want.phi) begin
          $error("phi_q16: expected %h, got %h", want.phi, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[63:32] !== want.mean) begin
          $error("mean_ms: expected %0d, got %0d", want.mean, out_tdata[63:32]);
          mismatches++;
        end
        if (out_tdata[74:64] !== want.count) begin
          $error("sample_count: expected %0d, got %0d", want.count, out_tdata[74:64]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_heartbeat_phi_failure_detector: errors");
      $finish;
    end
  end

  task automatic write_reg(hpfd_pkg::cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hpfd_pkg::CFG_INITIAL: init_ms = val;
      hpfd_pkg::CFG_MAX:     max_ms  = val;
      hpfd_pkg::CFG_MIN:     min_ms  = val;
      default: ;   // unused index, write is dropped
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(logic mode, logic [47:0] stamp);
    beat_item_t it;
    it.mode  = mode;
    it.stamp = stamp;
    pending_beats.insert(pending_beats.size(), it);
    if (mode == MODE_ARRIVAL) gen_last = stamp;
  endtask

  task automatic queue_random_query(logic [31:0] qspan);
    logic [47:0] stamp;
    case ($urandom_range(0, 9))
      0:       stamp = gen_last;
      1:       stamp = gen_last - 48'($urandom_range(1, 1000));
      2:       stamp = {16'($urandom), $urandom};
      default: stamp = gen_last + 48'($urandom_range(qspan, 0));
    endcase
    queue_item(MODE_QUERY, stamp);
  endtask

  // Heartbeat train with gaps around [lo, hi], interleaved queries and some junk arrivals
  task automatic queue_beats(int n, logic [31:0] lo, logic [31:0] hi, int query_pct,
                             int noise_pct, logic [31:0] qspan);
    int          pick;
    logic [63:0] gap;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < query_pct) begin
        queue_random_query(qspan);
      end else if (pick < query_pct + noise_pct) begin
        if ($urandom_range(0, 1))
          queue_item(MODE_ARRIVAL, gen_last - 48'($urandom_range(1, 5000)));
        else
          queue_item(MODE_ARRIVAL, {16'($urandom), $urandom});
      end else begin
        case ($urandom_range(0, 15))
          0:       gap = 64'(lo);
          1:       gap = 64'(hi);
          2:       gap = 64'(hi) + 64'd1;
          3:       gap = (lo == 0) ? 64'd0 : 64'(lo) - 64'd1;
          default: gap = 64'($urandom_range(hi, lo));
        endcase
        queue_item(MODE_ARRIVAL, gen_last + gap[47:0]);
      end
    end
  endtask

  // Sender holds off until every prediction is matched, then lets the core go quiet
  task automatic drain_results();
    while (pending_beats.size() != 0 || in_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] lo_r, hi_r;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset register values: a query with no arrival yet reports no samples
    queue_item(MODE_QUERY, 48'd123);
    drain_results();

    // zero initial interval gives an all-zero window first
    write_reg(hpfd_pkg::CFG_INITIAL, 32'd0);
    queue_item(MODE_ARRIVAL, 48'd100);            // first arrival, initial stored
    queue_item(MODE_QUERY, gen_last);             // zero mean, zero elapsed
    queue_item(MODE_QUERY, gen_last + 48'd1);     // zero mean, elapsed > 0
    queue_item(MODE_ARRIVAL, gen_last);           // zero gap at min
    queue_item(MODE_QUERY, TIME_MAX);
    queue_item(MODE_ARRIVAL, gen_last + 48'd10000);   // gap at max
    queue_item(MODE_QUERY, gen_last + 48'd5000);
    queue_item(MODE_QUERY, gen_last);
    queue_item(MODE_QUERY, gen_last - 48'd1);         // earlier than last arrival
    queue_item(MODE_QUERY, gen_last + 48'd218453333); // ratio just under 65536
    queue_item(MODE_QUERY, gen_last + 48'd218453334); // ratio saturates
    queue_item(MODE_ARRIVAL, gen_last + 48'd10001);   // gap above max
    queue_item(MODE_ARRIVAL, gen_last - 48'd7);       // backward stamp
    queue_item(MODE_ARRIVAL, gen_last + 48'd1);
    queue_item(MODE_ARRIVAL, TIME_MAX);
    queue_item(MODE_QUERY, TIME_MAX);
    queue_item(MODE_ARRIVAL, 48'd0);
    queue_item(MODE_ARRIVAL, gen_last + 48'd1);
    drain_results();

    // widest range, no idling on either side for this stretch
    idle_pct = 0;
    write_reg(hpfd_pkg::CFG_INITIAL, IVL_MAX);
    write_reg(hpfd_pkg::CFG_MAX, IVL_MAX);
    write_reg(hpfd_pkg::CFG_MIN, 32'd0);
    write_reg(hpfd_pkg::CFG_UNUSED, $urandom);
    queue_item(MODE_ARRIVAL, gen_last + 48'hFFFF_FFFF);   // largest gap stored
    queue_item(MODE_ARRIVAL, gen_last + 48'h1_0000_0000); // one past 32 bits
    queue_item(MODE_QUERY, gen_last + 48'hFFFF_FFFF);
    queue_beats(40, 32'd0, IVL_MAX, 15, 8, IVL_MAX);
    drain_results();
    idle_pct = 19;

    // single accepted gap value
    write_reg(hpfd_pkg::CFG_MIN, 32'd5);
    write_reg(hpfd_pkg::CFG_MAX, 32'd5);
    queue_beats(20, 32'd5, 32'd5, 15, 8, 32'd40);
    drain_results();

    // min above max: every gap is dropped
    write_reg(hpfd_pkg::CFG_MIN, IVL_MAX);
    write_reg(hpfd_pkg::CFG_MAX, 32'd0);
    queue_beats(20, IVL_MAX, 32'd0, 15, 8, 32'd5000);
    drain_results();

    // long realistic train, mostly stored gaps
    lo_r = $urandom_range(0, 50);
    hi_r = $urandom_range(2000, 3000);
    write_reg(hpfd_pkg::CFG_INITIAL, $urandom);
    write_reg(hpfd_pkg::CFG_MIN, lo_r);
    write_reg(hpfd_pkg::CFG_MAX, hi_r);
    queue_beats(960, lo_r, hi_r, 2, 1, 32'd9000);
    drain_results();

    // narrower band, fills the window and evicts from it
    write_reg(hpfd_pkg::CFG_MIN, 32'd100);
    write_reg(hpfd_pkg::CFG_MAX, 32'd200);
    queue_beats(240, 32'd100, 32'd200, 6, 2, 32'd600);
    drain_results();

    if (expected_verdicts.size() != 0) begin
      $error("%0d results never arrived", expected_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("tb_heartbeat_phi_failure_detector: clean");
    else
      $display("tb_heartbeat_phi_failure_detector: errors");
    $finish;
  end

endmodule

### heartbeat_phi_failure_detector.f
rtl/hpfd_pkg.sv
rtl/heartbeat_phi_failure_detector.sv
tb/sv/tb_heartbeat_phi_failure_detector.sv
